[src/gated_nearest_landmark_match_defines.svh]
// Assertion macros shared by the landmark matcher RTL.
// No dependencies.
`ifndef GATED_NEAREST_LANDMARK_MATCH_DEFINES_SVH
`define GATED_NEAREST_LANDMARK_MATCH_DEFINES_SVH
`define GNLM_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("gnlm check failed");
`define GNLM_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("gnlm check failed");
`endif

[src/gnlm_pkg.sv]
// Package of the landmark matcher: widths, class codes, register indexes, states.
// No dependencies.
package gnlm_pkg;
    localparam int MAP_DEPTH_DEF   = 256;
    localparam int COORD_WIDTH_DEF = 24;
    localparam int CLASS_W = 3;
    localparam int IDX_W   = 8;
    localparam int DIST_W  = 49;
    localparam int CFG_W   = 20;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CLASS_W-1:0] CLASS_NONE = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_ORANGE = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_BIG_ORANGE = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] REG_GATE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CLASS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COUNT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_PASS, ST_GATE, ST_OUT
    } state_t;

    // Token handed from cell to cell; each cell holds one landmark.
    typedef struct packed {
        logic        valid;
        logic        enforce;
        logic [DIST_W-1:0] best_d;
        logic [IDX_W-1:0]  best_i;
        logic        have;
    } token_t;

    function automatic logic class_ok(input logic en, input logic [CLASS_W-1:0] q,
                                      input logic [CLASS_W-1:0] c);
        logic r;
        if (!en || q == CLASS_NONE)
            r = 1'b1;
        else if (q == CLASS_ORANGE)
            r = (c == CLASS_ORANGE) || (c == CLASS_BIG_ORANGE);
        else
            r = (q == c);
        return r;
    endfunction
endpackage

[src/gnlm_cell.sv]
// One landmark cell: stores an entry, scores the passing query against it.
// Depends on gnlm_pkg.
module gnlm_cell #(
    parameter int COORD_WIDTH = gnlm_pkg::COORD_WIDTH_DEF,
    parameter int INDEX = 0
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  logic signed [COORD_WIDTH-1:0] wx,
    input  logic signed [COORD_WIDTH-1:0] wy,
    input  logic [gnlm_pkg::CLASS_W-1:0] wc,
    input  logic active,
    input  logic match_en,
    input  logic signed [COORD_WIDTH-1:0] qx,
    input  logic signed [COORD_WIDTH-1:0] qy,
    input  logic [gnlm_pkg::CLASS_W-1:0] qc,
    input  gnlm_pkg::token_t tin,
    output gnlm_pkg::token_t tout,
    output logic found
);
    import gnlm_pkg::*;
    logic signed [COORD_WIDTH-1:0] x_reg, y_reg;
    logic [CLASS_W-1:0] c_reg;
    logic [COORD_WIDTH:0] dx, dy;
    logic [2*COORD_WIDTH+1:0] d;
    logic consider;
    token_t t_reg, t_next;
    logic found_reg, found_next;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            x_reg <= wx;
            y_reg <= wy;
            c_reg <= wc;
        end
    end

    always_comb
    begin
        dx = (qx >= x_reg) ?
             ({qx[COORD_WIDTH-1], qx} - {x_reg[COORD_WIDTH-1], x_reg}) :
             ({x_reg[COORD_WIDTH-1], x_reg} - {qx[COORD_WIDTH-1], qx});
        dy = (qy >= y_reg) ?
             ({qy[COORD_WIDTH-1], qy} - {y_reg[COORD_WIDTH-1], y_reg}) :
             ({y_reg[COORD_WIDTH-1], y_reg} - {qy[COORD_WIDTH-1], qy});
        d = (2*COORD_WIDTH+2)'(dx * dx) + (2*COORD_WIDTH+2)'(dy * dy);
        consider = tin.valid && active && (!tin.enforce || class_ok(match_en, qc, c_reg));
        t_next = tin;
        found_next = 1'b0;
        if (consider && (!tin.have || DIST_W'(d) < tin.best_d))
        begin
            t_next.best_d = DIST_W'(d);
            t_next.best_i = IDX_W'(INDEX);
            t_next.have = 1'b1;
            found_next = tin.enforce;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            t_reg <= t_next;
            found_reg <= found_next;
        end
    end

    assign tout = t_reg;
    assign found = found_reg;
endmodule

[src/gnlm_chain.sv]
// Row of landmark cells; a token walks one cell per cycle.
// Depends on gnlm_pkg and gnlm_cell.
module gnlm_chain #(
    parameter int MAP_DEPTH = gnlm_pkg::MAP_DEPTH_DEF,
    parameter int COORD_WIDTH = gnlm_pkg::COORD_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  logic [gnlm_pkg::IDX_W-1:0] wr_index,
    input  logic signed [COORD_WIDTH-1:0] wx,
    input  logic signed [COORD_WIDTH-1:0] wy,
    input  logic [gnlm_pkg::CLASS_W-1:0] wc,
    input  logic [MAP_DEPTH-1:0] active,
    input  logic match_en,
    input  logic signed [COORD_WIDTH-1:0] qx,
    input  logic signed [COORD_WIDTH-1:0] qy,
    input  logic [gnlm_pkg::CLASS_W-1:0] qc,
    input  gnlm_pkg::token_t tin,
    output gnlm_pkg::token_t tout,
    output logic any_found
);
    import gnlm_pkg::*;
    token_t tk [MAP_DEPTH+1];
    logic [MAP_DEPTH-1:0] fnd;
    logic found_reg;

    assign tk[0] = tin;
    for (genvar i = 0; i < MAP_DEPTH; i++)
    begin : g_cell
        gnlm_cell #(.COORD_WIDTH(COORD_WIDTH), .INDEX(i)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .wr(wr && (32'(wr_index) == i)),
            .wx(wx), .wy(wy), .wc(wc),
            .active(active[i]), .match_en(match_en),
            .qx(qx), .qy(qy), .qc(qc),
            .tin(tk[i]), .tout(tk[i+1]), .found(fnd[i]));
    end

    // Sticky flag: some compatible entry was seen during this pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else if (tin.valid)
            found_reg <= 1'b0;
        else if (|fnd)
            found_reg <= 1'b1;
    end

    assign tout = tk[MAP_DEPTH];
    assign any_found = found_reg;
endmodule

[src/gated_nearest_landmark_match.sv]
// Top level of the gated nearest-landmark matcher: control and output register.
// Depends on gnlm_pkg, gnlm_chain and the defines header.
//
// channel | dir | handshake        | payload
// in      | in  | in_valid/stall   | action entry_index pos_x pos_y class_code
// out     | out | out_valid/stall  | matched landmark_index distance_sq
// cfg     | in  | cfg_we           | cfg_index cfg_data
//
// A load answers through ST_GATE and ST_OUT once accepted. A query walks the cell
// row once, and a second time when no entry has a compatible class; the token
// advances one cell per cycle, and the result then passes ST_GATE and ST_OUT. Reset
// clears control only; map entries are undefined until loaded. A stalled output
// holds the item, and no new item is accepted until it leaves.
`include "gated_nearest_landmark_match_defines.svh"
module gated_nearest_landmark_match #(
    parameter int MAP_DEPTH = gnlm_pkg::MAP_DEPTH_DEF,
    parameter int COORD_WIDTH = gnlm_pkg::COORD_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic action,
    input  logic [gnlm_pkg::IDX_W-1:0] entry_index,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic [gnlm_pkg::CLASS_W-1:0] class_code,
    output logic out_valid,
    input  logic out_stall,
    output logic matched,
    output logic [gnlm_pkg::IDX_W-1:0] landmark_index,
    output logic [gnlm_pkg::DIST_W-1:0] distance_sq,
    input  logic cfg_we,
    input  logic [gnlm_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [gnlm_pkg::CFG_W-1:0] cfg_data
);
    import gnlm_pkg::*;
    localparam int CNT_W = $clog2(MAP_DEPTH+1);

    state_t state_reg, state_next;
    logic [CFG_W-1:0] gate_reg;
    logic cme_reg;
    logic [8:0] count_reg;
    logic [CNT_W-1:0] n_eff;
    logic [MAP_DEPTH-1:0] active;
    logic signed [COORD_WIDTH-1:0] qx_reg, qy_reg;
    logic [CLASS_W-1:0] qc_reg;
    logic pass2_reg, pass2_next;
    token_t tin, tout;
    logic any_found;
    logic [2*CFG_W-1:0] gate_sq_reg;
    token_t res_reg;
    logic ov_reg, m_reg;
    logic [IDX_W-1:0] bi_reg;
    logic [DIST_W-1:0] ds_reg;
    logic acc, wr;

    assign acc = in_valid && !in_stall;
    assign wr = acc && !action && (32'(entry_index) < MAP_DEPTH);
    assign n_eff = (32'(count_reg) > MAP_DEPTH) ? CNT_W'(MAP_DEPTH) : CNT_W'(count_reg);

    for (genvar i = 0; i < MAP_DEPTH; i++)
    begin : g_act
        assign active[i] = (i < 32'(n_eff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg <= CFG_W'(1500);
            cme_reg <= 1'b1;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GATE:  gate_reg <= cfg_data;
                REG_CLASS: cme_reg <= cfg_data[0];
                REG_COUNT: count_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        gate_sq_reg <= gate_reg * gate_reg;
        if (acc)
        begin
            qx_reg <= pos_x;
            qy_reg <= pos_y;
            qc_reg <= class_code;
        end
        // A new item starts with no candidate, so a load reports zeros.
        if (tout.valid)
            res_reg <= tout;
        else if (state_reg == ST_IDLE && acc)
            res_reg.have <= 1'b0;
    end

    assign in_stall = (state_reg != ST_IDLE) || ov_reg;

    always_comb
    begin
        state_next = state_reg;
        pass2_next = pass2_reg;
        case (state_reg)
            ST_IDLE:
                if (acc)
                begin
                    state_next = action ? ST_READ : ST_GATE;
                    pass2_next = 1'b0;
                end
            ST_READ: state_next = ST_PASS;
            ST_PASS:
                if (tout.valid)
                begin
                    if (!pass2_reg && !any_found && !(|(tout.have)))
                    begin
                        state_next = ST_READ;
                        pass2_next = 1'b1;
                    end
                    else
                        state_next = ST_GATE;
                end
            ST_GATE: state_next = ST_OUT;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        tin = '0;
        tin.valid = (state_reg == ST_READ);
        tin.enforce = !pass2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass2_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass2_reg <= pass2_next;
            if (state_reg == ST_OUT)
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT)
        begin
            m_reg <= res_reg.have && (64'(res_reg.best_d) <= 64'(gate_sq_reg));
            bi_reg <= res_reg.have ? res_reg.best_i : '0;
            ds_reg <= res_reg.have ? res_reg.best_d : '0;
        end
    end

    assign out_valid = ov_reg;
    assign matched = m_reg;
    assign landmark_index = bi_reg;
    assign distance_sq = ds_reg;

    gnlm_chain #(.MAP_DEPTH(MAP_DEPTH), .COORD_WIDTH(COORD_WIDTH)) u_chain (
        .clk(clk), .rst_n(rst_n), .wr(wr), .wr_index(entry_index),
        .wx(pos_x), .wy(pos_y), .wc(class_code),
        .active(active), .match_en(cme_reg),
        .qx(qx_reg), .qy(qy_reg), .qc(qc_reg),
        .tin(tin), .tout(tout), .any_found(any_found));

    `GNLM_ASSERT_IMPL(a_stall_busy, clk, rst_n, state_reg != ST_IDLE, in_stall)
    `GNLM_ASSERT_NEXT(a_out_after, clk, rst_n, state_reg == ST_OUT, out_valid)
    `GNLM_ASSERT_IMPL(a_tok_pass, clk, rst_n, tout.valid, state_reg == ST_PASS)
endmodule
